// ===== src/tcpct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpct_pkg
// Shared types and constants of the TCP connection table.
// ----------------------------------------------------------------------------
package tcpct_pkg;

  localparam int unsigned ETHER_BYTES   = 14;
  localparam int unsigned IP_MIN_BYTES  = 20;
  localparam int unsigned TCP_MIN_BYTES = 20;
  localparam int unsigned MIN_FRAME     = ETHER_BYTES + IP_MIN_BYTES;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_HIT   = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } key_t;

  typedef struct packed {
    logic too_short;
    key_t key;
  } item_t;

endpackage
`default_nettype wire

// ===== src/tcpct_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpct_front
// Input stage: takes an item, runs the header length checks, registers the
// classified item for the queue.
// ----------------------------------------------------------------------------
module tcpct_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_frame_length,
  input  wire logic [3:0]         in_ip_header_words,
  input  wire logic [31:0]        in_source_address,
  input  wire logic [31:0]        in_destination_address,
  input  wire logic [15:0]        in_source_port,
  input  wire logic [15:0]        in_destination_port,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output tcpct_pkg::item_t        push_data
);
  import tcpct_pkg::*;

  logic        valid_r;
  item_t       item_r;
  item_t       item_nxt;
  logic [15:0] rest;
  logic [15:0] tail;
  logic [5:0]  hdr_bytes;

  assign hdr_bytes = {in_ip_header_words, 2'b00};
  assign rest      = in_frame_length - 16'(ETHER_BYTES);
  assign tail      = rest - 16'(hdr_bytes);

  always_comb begin
    item_nxt.key.src_addr = in_source_address;
    item_nxt.key.dst_addr = in_destination_address;
    item_nxt.key.sport    = in_source_port;
    item_nxt.key.dport    = in_destination_port;
    item_nxt.too_short    = (in_frame_length < 16'(MIN_FRAME)) ||
                            (rest < 16'(hdr_bytes)) ||
                            (tail < 16'(TCP_MIN_BYTES));
  end

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/tcpct_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpct_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module tcpct_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire tcpct_pkg::item_t   push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output tcpct_pkg::item_t        pop_data
);
  import tcpct_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             push;
  logic             pop;

  assign push_ready = fill_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/tcpct_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpct_back
// Lookup engine: linear search of the key store, one key per cycle in both
// directions, append on a miss, result register toward the output.
// ----------------------------------------------------------------------------
module tcpct_back #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire tcpct_pkg::item_t   pop_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tcpct_pkg::status_t      out_status,
  output logic [IDX_W-1:0]        out_index,
  output logic [CNT_W-1:0]        out_count
);
  import tcpct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_OUT
  } state_t;

  key_t             mem [TABLE_DEPTH];
  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  key_t             key_r;
  logic [CNT_W-1:0] rd_addr_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  key_t             rd_data_r;
  logic             out_valid_r;
  status_t          status_r;
  logic [IDX_W-1:0] index_r;

  logic issue;
  logic fwd;
  logic rev;
  logic match;
  logic miss;
  logic room;
  logic wr_en;

  assign issue = (state_r == S_SEARCH) && (rd_addr_r != count_r);
  assign fwd   = (rd_data_r.src_addr == key_r.src_addr) &&
                 (rd_data_r.dst_addr == key_r.dst_addr) &&
                 (rd_data_r.sport == key_r.sport) &&
                 (rd_data_r.dport == key_r.dport);
  assign rev   = (rd_data_r.src_addr == key_r.dst_addr) &&
                 (rd_data_r.dst_addr == key_r.src_addr) &&
                 (rd_data_r.sport == key_r.dport) &&
                 (rd_data_r.dport == key_r.sport);
  assign match = cmp_vld_r && (fwd || rev);
  assign miss  = (state_r == S_SEARCH) && !issue && !cmp_vld_r;
  assign room  = count_r != CNT_W'(TABLE_DEPTH);
  assign wr_en = miss && room;

  assign pop_ready  = state_r == S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_index  = index_r;
  assign out_count  = count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= key_r;
    end
    rd_data_r <= mem[rd_addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            key_r     <= pop_data.key;
            rd_addr_r <= '0;
            cmp_vld_r <= 1'b0;
            if (pop_data.too_short) begin
              status_r    <= ST_SHORT;
              index_r     <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          cmp_vld_r <= issue;
          cmp_idx_r <= rd_addr_r[IDX_W-1:0];
          rd_addr_r <= rd_addr_r + CNT_W'(issue);
          if (match) begin
            status_r    <= ST_HIT;
            index_r     <= cmp_idx_r;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (miss) begin
            if (room) begin
              status_r <= ST_NEW;
              index_r  <= count_r[IDX_W-1:0];
              count_r  <= count_r + 1'b1;
            end else begin
              status_r <= ST_FULL;
              index_r  <= '0;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/tcp_connection_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_connection_table_core
// Bidirectional TCP connection table: length checks, lookup and insert.
// ----------------------------------------------------------------------------
// Each item carries one frame's length fields and its address/port key. A
// frame too short for Ethernet, IP with options and a TCP header returns
// status 2 at once. Otherwise the stored keys are searched in order, one key
// per cycle through the single registered read port of the key memory,
// matching either direction; a miss appends the key (status 0) or reports a
// full table (status 3). The input stage and a two-item queue keep accepting
// while a lookup or a result is pending. The key memory needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module tcp_connection_table_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_frame_length,
  input  wire logic [3:0]  in_ip_header_words,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_destination_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [5:0]       out_entry_index,
  output logic [6:0]       out_connection_count
);
  import tcpct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             push_valid;
  logic             push_ready;
  item_t            push_data;
  logic             pop_valid;
  logic             pop_ready;
  item_t            pop_data;
  status_t          status;
  logic [IDX_W-1:0] index;
  logic [CNT_W-1:0] count;

  tcpct_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_frame_length        (in_frame_length),
    .in_ip_header_words     (in_ip_header_words),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_source_port         (in_source_port),
    .in_destination_port    (in_destination_port),
    .push_valid             (push_valid),
    .push_ready             (push_ready),
    .push_data              (push_data)
  );

  tcpct_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcpct_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (status),
    .out_index  (index),
    .out_count  (count)
  );

  assign out_status           = status;
  assign out_entry_index      = 6'(index);
  assign out_connection_count = 7'(count);

endmodule
`default_nettype wire

// ===== src/tcpct_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpct_checker
// Port-level assertions for the TCP connection table.
// ----------------------------------------------------------------------------
module tcpct_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_entry_index,
  input wire logic [6:0] out_connection_count
);
  import tcpct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_index) && $stable(out_connection_count))
    else $error("result changed while stalled");

  a_short_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_entry_index == 6'd0)
    else $error("too-short item with nonzero index");

  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_index == 6'd0)
    else $error("table-full item with nonzero index");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW |->
      (TABLE_DEPTH > 64) || (out_connection_count == 7'(out_entry_index) + 7'd1))
    else $error("insert slot does not match count");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HIT |->
      (TABLE_DEPTH > 64) || (7'(out_entry_index) < out_connection_count))
    else $error("hit beyond stored entries");

endmodule

bind tcp_connection_table_core tcpct_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (.*);
`default_nettype wire

// ===== bench/tcp_connection_table_core_test.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_table_core_test
// Self-checking bench for the TCP connection table core. Frames are driven
// through the valid/ready input with random gaps. A shadow table predicts
// the length-check verdict, the bidirectional lookup, the insert and the
// full-table case. A checker compares each result item against the oldest
// prediction while the result side stalls at random.
// ----------------------------------------------------------------------------
module tcp_connection_table_core_test;
  import tcpct_pkg::*;

  localparam int unsigned TABLE_SLOTS  = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned RANDOM_ITEMS = 650;

  typedef struct {
    status_t    status;
    logic [5:0] index;
    logic [6:0] count;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_frame_length;
  logic [3:0]  in_ip_header_words;
  logic [31:0] in_source_address;
  logic [31:0] in_destination_address;
  logic [15:0] in_source_port;
  logic [15:0] in_destination_port;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [5:0]  out_entry_index;
  logic [6:0]  out_connection_count;

  key_t        known_keys [TABLE_SLOTS];
  int unsigned known_count;
  key_t        seen_keys [$];
  verdict_t    verdict_q [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          idle_on;

  tcp_connection_table_core #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_frame_length        (in_frame_length),
    .in_ip_header_words     (in_ip_header_words),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_source_port         (in_source_port),
    .in_destination_port    (in_destination_port),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_entry_index        (out_entry_index),
    .out_connection_count   (out_connection_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic key_t swap_key(input key_t k);
    key_t r;
    r.src_addr = k.dst_addr;
    r.dst_addr = k.src_addr;
    r.sport    = k.dport;
    r.dport    = k.sport;
    return r;
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.src_addr = $urandom;
    k.dst_addr = $urandom;
    k.sport    = 16'($urandom);
    k.dport    = 16'($urandom);
    return k;
  endfunction

  // Shadow table: length checks, lookup in both directions, append on miss.
  function automatic verdict_t predict_verdict(input logic [15:0] flen,
                                               input logic [3:0] hw, input key_t k);
    verdict_t    v;
    int unsigned rest;
    int unsigned hdr;
    bit          hit;
    v.status = ST_SHORT;
    v.index  = '0;
    hit      = 1'b0;
    hdr      = hw;
    hdr      = hdr * 4;
    if (flen >= MIN_FRAME) begin
      rest = flen - ETHER_BYTES;
      if (rest >= hdr && rest - hdr >= TCP_MIN_BYTES) begin
        for (int unsigned i = 0; i < known_count && !hit; i++) begin
          if (known_keys[i] == k || known_keys[i] == swap_key(k)) begin
            hit      = 1'b1;
            v.status = ST_HIT;
            v.index  = 6'(i);
          end
        end
        if (!hit) begin
          if (known_count < TABLE_SLOTS) begin
            known_keys[known_count] = k;
            v.status = ST_NEW;
            v.index  = 6'(known_count);
            known_count++;
          end else begin
            v.status = ST_FULL;
          end
        end
      end
    end
    v.count = 7'(known_count);
    return v;
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      stall_left = idle_on ? $urandom_range(0, 9) : 0;
      if (verdict_q.size() == 0) begin
        $error("result item with no frame pending");
        err_count++;
      end else begin
        v = verdict_q.pop_front();
        if (out_status !== v.status) begin
          $error("status: expected %0d, got %0d", v.status, out_status);
          err_count++;
        end
        if (out_entry_index !== v.index) begin
          $error("entry_index: expected %0d, got %0d", v.index, out_entry_index);
          err_count++;
        end
        if (out_connection_count !== v.count) begin
          $error("connection_count: expected %0d, got %0d", v.count,
                 out_connection_count);
          err_count++;
        end
      end
    end
  end

  task automatic send_frame(input logic [15:0] flen, input logic [3:0] hw,
                            input key_t k);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid               <= 1'b1;
    in_frame_length        <= flen;
    in_ip_header_words     <= hw;
    in_source_address      <= k.src_addr;
    in_destination_address <= k.dst_addr;
    in_source_port         <= k.sport;
    in_destination_port    <= k.dport;
    verdict_q.push_back(predict_verdict(flen, hw, k));
    seen_keys.push_back(k);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_length_checks();
    key_t k;
    k = '0;
    send_frame(16'd0, 4'd5, k);
    send_frame(16'd33, 4'd5, k);
    send_frame(16'd34, 4'd5, k);
    send_frame(16'd53, 4'd5, k);
    send_frame(16'd54, 4'd5, k);
    k = '1;
    send_frame(16'd34, 4'd0, k);
    k = random_key();
    send_frame(16'd38, 4'd1, k);
    k = random_key();
    send_frame(16'd37, 4'd1, k);
    send_frame(16'd40, 4'd15, k);
    send_frame(16'd93, 4'd15, k);
    send_frame(16'd94, 4'd15, k);
    send_frame(16'hFFFF, 4'd15, random_key());
  endtask

  task automatic test_reverse_match();
    key_t k;
    key_t p;
    k = random_key();
    send_frame(16'd60, 4'd5, k);
    send_frame(16'd1500, 4'd5, k);
    send_frame(16'd60, 4'd6, swap_key(k));
    p = swap_key(k);
    p.sport = k.sport;
    p.dport = k.dport;
    send_frame(16'd60, 4'd5, p);
    k.dst_addr = k.src_addr;
    k.dport    = k.sport;
    send_frame(16'd60, 4'd5, k);
    send_frame(16'd60, 4'd5, swap_key(k));
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_frame(16'd60, 4'd5, seen_keys[$urandom_range(0, seen_keys.size() - 1)]);
    wait_drained();
    send_frame(16'd60, 4'd5, random_key());
  endtask

  task automatic test_random_traffic();
    key_t        k;
    logic [3:0]  hw;
    int unsigned lo;
    int unsigned pick;
    logic [15:0] flen;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) idle_on = $urandom_range(0, 3) != 0;
      if (n == RANDOM_ITEMS / 2) wait_drained();
      hw   = 4'($urandom);
      lo   = MIN_FRAME + hw * 4;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) flen = 16'(lo);
      else flen = 16'($urandom_range(65535, lo));
      if (pick < 12) begin
        // broken frame: one byte or more short of the headers
        flen = 16'($urandom_range(lo - 1, 0));
        k    = random_key();
      end else if (pick < 15) begin
        flen = 16'($urandom);
        k    = random_key();
      end else if (pick < 60) begin
        k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        if ($urandom_range(0, 1) == 1) k = swap_key(k);
      end else if (pick < 75) begin
        // near miss: one field differs from a key sent earlier
        k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        case ($urandom_range(0, 3))
          0: k.src_addr ^= 32'($urandom_range(1, 255));
          1: k.dst_addr ^= 32'h8000_0000;
          2: k.sport ^= 16'($urandom_range(1, 65535));
          default: k.dport ^= 16'h0001;
        endcase
      end else begin
        k = random_key();
      end
      send_frame(flen, hw, k);
    end
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    in_valid               = 1'b0;
    in_frame_length        = '0;
    in_ip_header_words     = '0;
    in_source_address      = '0;
    in_destination_address = '0;
    in_source_port         = '0;
    in_destination_port    = '0;
    out_ready              = 1'b0;
    stall_left             = 0;
    known_count            = 0;
    err_count              = 0;
    cycle_count            = 0;
    idle_on                = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_length_checks();
    idle_on = 1'b1;
    test_reverse_match();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
